FILE: hdl/decimal_number_string_parser_top_macros.svh
// Assertion macros for the decimal number string parser.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DECIMAL_NUMBER_STRING_PARSER_TOP_MACROS_SVH
`define DECIMAL_NUMBER_STRING_PARSER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define DNSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Checked at every edge, reset included.
`define DNSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DNSP_ASSERT(lbl, clk, rstn, prop, msg)
`define DNSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/dnsp_pkg.sv
// Shared types and constants for the decimal number string parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package dnsp_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_MAX_DIV10     = 8'd0;
  localparam logic [7:0] CFG_LAST_DIGIT    = 8'd1;
  localparam logic [7:0] CFG_SIGNED_TARGET = 8'd2;
  localparam logic [7:0] CFG_KEEP_FRACTION = 8'd3;

  localparam logic [63:0] MAX_DIV10_RST  = 64'd1844674407370955161;
  localparam logic [3:0]  LAST_DIGIT_RST = 4'd5;

  // Result kinds
  localparam logic [1:0] KIND_INT   = 2'd0;
  localparam logic [1:0] KIND_FLOAT = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  localparam logic [23:0] EXP_LIMIT  = 24'd1000000;
  localparam logic [23:0] EXP_CEIL   = 24'd10000009;
  localparam logic [4:0]  FRAC_MAX   = 5'd31;
  localparam int          QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_DOT,
    CLS_EXP,
    CLS_PLUS,
    CLS_MINUS,
    CLS_BLANK,
    CLS_OTHER
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        is_last;
  } dnsp_item_t;

  typedef struct packed {
    logic [63:0] max_div10;
    logic [3:0]  last_digit;
    logic        signed_target;
    logic        keep_fraction;
  } dnsp_cfg_t;

endpackage

`default_nettype wire

FILE: hdl/dnsp_queue.sv
// Short word queue between the classifier and the parse engine.
// Depends on dnsp_pkg for the queued word type.
`default_nettype none

`include "decimal_number_string_parser_top_macros.svh"

module dnsp_queue
  import dnsp_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire dnsp_item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  output dnsp_item_t      item_o,
  input  wire logic       pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  dnsp_item_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [CntW-1:0]       cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        mem_q[wr_q] <= item_i;
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `DNSP_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntFull, "queue count past depth")
  `DNSP_ASSERT(a_empty_ptrs, clk_i, rst_ni, cnt_q == '0 |-> rd_q == wr_q, "empty queue with split pointers")
  `DNSP_ASSERT(a_push_lands, clk_i, rst_ni, do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1, "push lost")

endmodule

`default_nettype wire

FILE: hdl/dnsp_front.sv
// Character classifier: sorts each input character into a syntax class and digit.
// Depends on dnsp_pkg for the class enum and the queued word type.
`default_nettype none

module dnsp_front
  import dnsp_pkg::*;
(
  input  wire logic [7:0] char_code_i,
  input  wire logic       is_last_i,
  output dnsp_item_t      item_o
);

  logic is_digit;

  assign is_digit = (char_code_i >= 8'd48) && (char_code_i <= 8'd57);

  always_comb begin
    item_o.is_last = is_last_i;
    item_o.digit   = is_digit ? 4'(char_code_i - 8'd48) : 4'd0;
    if (is_digit) begin
      item_o.cls = CLS_DIGIT;
    end else begin
      unique case (char_code_i)
        8'd46:        item_o.cls = CLS_DOT;
        8'd69, 8'd101: item_o.cls = CLS_EXP;
        8'd43:        item_o.cls = CLS_PLUS;
        8'd45:        item_o.cls = CLS_MINUS;
        8'd32, 8'd9:  item_o.cls = CLS_BLANK;
        default:      item_o.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dnsp_back.sv
// Parse engine: runs the field syntax state machine, digit accumulation and
// overflow checks, and holds the result in an output register. Uses dnsp_pkg.
`default_nettype none

`include "decimal_number_string_parser_top_macros.svh"

module dnsp_back
  import dnsp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire dnsp_cfg_t    cfg_i,
  input  wire logic         q_valid_i,
  input  wire dnsp_item_t   item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [1:0]        kind_o,
  output logic [63:0]       magnitude_o,
  output logic              negative_o,
  output logic              overflow_o,
  output logic signed [24:0] scale_shift_o,
  output logic [7:0]        precision_o
);

  typedef enum logic [3:0] {
    ST_EMPTY, ST_SIGN, ST_INT, ST_FLOAT, ST_FRACT, ST_EXP, ST_EXPSIGN, ST_MANT, ST_BAD
  } parse_state_e;

  parse_state_e state_q, state_d, dig_st;
  logic         trail_q, trail_d;
  logic [63:0]  value_q, value_d, value_x10;
  logic [23:0]  exp_q, exp_d, exp_x10;
  logic [4:0]   frac_q, frac_d;
  logic [7:0]   cnt_q, cnt_d, cnt_inc;
  logic         neg_q, neg_d, ovf_q, ovf_d;
  logic         fits;

  logic [1:0]   res_kind;
  logic         res_ovf;
  logic [24:0]  res_scale;

  logic         out_valid_q;
  logic [1:0]   kind_q;
  logic [63:0]  mag_q;
  logic         neg_out_q, ovf_out_q;
  logic [24:0]  scale_q;
  logic [7:0]   prec_q;

  assign value_x10 = (value_q << 3) + (value_q << 1);
  assign exp_x10   = (exp_q << 3) + (exp_q << 1);
  assign cnt_inc   = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
  assign fits      = (value_q < cfg_i.max_div10) ||
                     ((value_q == cfg_i.max_div10) && (item_i.digit <= cfg_i.last_digit));

  // Only a field end needs the output slot
  assign pop_o = q_valid_i && (!item_i.is_last || !out_valid_q || !out_stall_i);

  always_comb begin
    unique case (state_q)
      ST_EMPTY, ST_SIGN:  dig_st = ST_INT;
      ST_FLOAT:           dig_st = ST_FRACT;
      ST_EXP, ST_EXPSIGN: dig_st = ST_MANT;
      default:            dig_st = state_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    trail_d = trail_q;
    value_d = value_q;
    exp_d   = exp_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    if (state_q != ST_BAD) begin
      if (trail_q) begin
        if (item_i.cls != CLS_BLANK) state_d = ST_BAD;
      end else begin
        unique case (item_i.cls)
          CLS_DIGIT: begin
            state_d = dig_st;
            if (dig_st == ST_INT) begin
              cnt_d = cnt_inc;
              if (fits) value_d = value_x10 + 64'(item_i.digit);
              else      ovf_d   = 1'b1;
            end else if (dig_st == ST_FRACT) begin
              if (cfg_i.keep_fraction && fits && frac_q < FRAC_MAX) begin
                cnt_d   = cnt_inc;
                frac_d  = frac_q + 5'd1;
                value_d = value_x10 + 64'(item_i.digit);
              end
            end else if (dig_st == ST_MANT) begin
              if (exp_q > EXP_LIMIT) ovf_d = 1'b1;
              else                   exp_d = exp_x10 + 24'(item_i.digit);
            end
          end
          CLS_DOT: state_d = (state_q == ST_INT) ? ST_FLOAT : ST_BAD;
          CLS_EXP: begin
            if (state_q == ST_INT || state_q == ST_FLOAT || state_q == ST_FRACT) begin
              state_d = ST_EXP;
            end else begin
              state_d = ST_BAD;
            end
          end
          CLS_PLUS, CLS_MINUS: begin
            if (state_q == ST_EMPTY) begin
              state_d = ST_SIGN;
              if (item_i.cls == CLS_MINUS) neg_d = 1'b1;
            end else if (state_q == ST_EXP) begin
              state_d = ST_EXPSIGN;
            end else begin
              state_d = ST_BAD;
            end
          end
          CLS_BLANK: begin
            if (state_q != ST_EMPTY) trail_d = 1'b1;
          end
          default: state_d = ST_BAD;
        endcase
      end
    end
  end

  always_comb begin
    priority if (state_d == ST_FLOAT || state_d == ST_FRACT || state_d == ST_MANT) begin
      res_kind = KIND_FLOAT;
    end else if (state_d == ST_INT) begin
      res_kind = KIND_INT;
    end else begin
      res_kind = KIND_BAD;
    end
    res_ovf   = ovf_d || (!cfg_i.signed_target && neg_d && (value_d != '0));
    res_scale = cfg_i.keep_fraction ? ({20'd0, frac_d} - {1'b0, exp_d}) : 25'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EMPTY;
      trail_q     <= 1'b0;
      value_q     <= '0;
      exp_q       <= '0;
      frac_q      <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_BAD;
      mag_q       <= '0;
      neg_out_q   <= 1'b0;
      ovf_out_q   <= 1'b0;
      scale_q     <= '0;
      prec_q      <= '0;
    end else begin
      if (pop_o && item_i.is_last) begin
        // Emit the result and clear the field
        out_valid_q <= 1'b1;
        kind_q      <= res_kind;
        if (res_kind == KIND_BAD) begin
          mag_q     <= '0;
          neg_out_q <= 1'b0;
          ovf_out_q <= 1'b0;
          scale_q   <= '0;
          prec_q    <= '0;
        end else begin
          mag_q     <= value_d;
          neg_out_q <= neg_d && !res_ovf;
          ovf_out_q <= res_ovf;
          scale_q   <= res_scale;
          prec_q    <= cnt_d;
        end
        state_q <= ST_EMPTY;
        trail_q <= 1'b0;
        value_q <= '0;
        exp_q   <= '0;
        frac_q  <= '0;
        cnt_q   <= '0;
        neg_q   <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        if (!out_stall_i) out_valid_q <= 1'b0;
        if (pop_o) begin
          state_q <= state_d;
          trail_q <= trail_d;
          value_q <= value_d;
          exp_q   <= exp_d;
          frac_q  <= frac_d;
          cnt_q   <= cnt_d;
          neg_q   <= neg_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign magnitude_o   = mag_q;
  assign negative_o    = neg_out_q;
  assign overflow_o    = ovf_out_q;
  assign scale_shift_o = scale_q;
  assign precision_o   = prec_q;

  `DNSP_ASSERT(a_last_emits, clk_i, rst_ni, pop_o && item_i.is_last |=> out_valid_q, "field end gave no result")
  `DNSP_ASSERT(a_last_clears, clk_i, rst_ni, pop_o && item_i.is_last |=> state_q == ST_EMPTY && value_q == '0 && !trail_q, "field state not cleared")
  `DNSP_ASSERT(a_ovf_not_neg, clk_i, rst_ni, out_valid_q && ovf_out_q |-> !neg_out_q, "negative flag with overflow")
  `DNSP_ASSERT_ALWAYS(a_exp_bound, clk_i, !rst_ni || exp_q <= EXP_CEIL, "exponent past its ceiling")

endmodule

`default_nettype wire

FILE: hdl/decimal_number_string_parser_top.sv
// Top level of the decimal number string parser: configuration registers,
// classifier, word queue and parse engine. Uses dnsp_pkg and the dnsp_* modules.
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_stall_o    char_code_i, is_last_i
//  out      source     out_valid_o / out_stall_i  kind_o .. precision_o
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One character per cycle sustained while no field end waits on a stalled result;
// the parse engine's update (multiply-by-ten add, compare to max_div10) sets that figure.
// A last character passes through the word queue; its result is held in the engine's output register.
// Reset clears the field state and loads the register defaults; no sweep follows.
// A stalled result blocks only the next field end; other characters keep flowing
// until the queue fills, then in_stall_o rises.
`default_nettype none

module decimal_number_string_parser_top
  import dnsp_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    char_code_i,
  input  wire logic          is_last_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         kind_o,
  output logic [63:0]        magnitude_o,
  output logic               negative_o,
  output logic               overflow_o,
  output logic signed [24:0] scale_shift_o,
  output logic [7:0]         precision_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [7:0]    cfg_index_i,
  input  wire logic [63:0]   cfg_data_i
);

  dnsp_cfg_t  cfg_q;
  dnsp_item_t front_item, q_item;
  logic       q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_div10     <= MAX_DIV10_RST;
      cfg_q.last_digit    <= LAST_DIGIT_RST;
      cfg_q.signed_target <= 1'b0;
      cfg_q.keep_fraction <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MAX_DIV10:     cfg_q.max_div10     <= cfg_data_i;
        CFG_LAST_DIGIT:    cfg_q.last_digit    <= cfg_data_i[3:0];
        CFG_SIGNED_TARGET: cfg_q.signed_target <= cfg_data_i[0];
        CFG_KEEP_FRACTION: cfg_q.keep_fraction <= cfg_data_i[0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  dnsp_front u_front (
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .item_o      (front_item)
  );

  dnsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  assign in_stall_o = q_full;

  dnsp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .item_i        (q_item),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .magnitude_o   (magnitude_o),
    .negative_o    (negative_o),
    .overflow_o    (overflow_o),
    .scale_shift_o (scale_shift_o),
    .precision_o   (precision_o)
  );

endmodule

`default_nettype wire

FILE: bench/decimal_number_string_parser_top_tb.sv
// Self-checking bench for decimal_number_string_parser_top: a queue-fed driver streams
// number text, an internal parser model predicts each field's result, a monitor checks it.
// Depends on dnsp_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module decimal_number_string_parser_top_tb
  import dnsp_pkg::*;
();

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef enum logic [3:0] {
    PS_EMPTY, PS_SIGN, PS_INT, PS_FLOAT, PS_FRACT, PS_EXP, PS_EXP_SIGN, PS_EXP_DIGITS, PS_BAD
  } parse_state_e;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        magnitude;
    logic               negative;
    logic               overflow;
    logic signed [24:0] scale_shift;
    logic [7:0]         precision;
  } number_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_code_i = 8'd0;
  logic               is_last_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         kind_o;
  logic [63:0]        magnitude_o;
  logic               negative_o;
  logic               overflow_o;
  logic signed [24:0] scale_shift_o;
  logic [7:0]         precision_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [7:0]         cfg_index_i = CFG_MAX_DIV10;
  logic [63:0]        cfg_data_i = 64'd0;

  // Configuration as the parser sees it
  logic [63:0] lim_div10 = MAX_DIV10_RST;
  logic [3:0]  lim_last = LAST_DIGIT_RST;
  logic        allow_negative = 1'b0;
  logic        keep_frac = 1'b1;

  // Field state of the parser model
  parse_state_e ps = PS_EMPTY;
  logic         trail = 1'b0;
  logic [63:0]  fld_value = 64'd0;
  logic [31:0]  fld_exp = 32'd0;
  logic [4:0]   fld_frac = 5'd0;
  logic [7:0]   fld_digits = 8'd0;
  logic         fld_neg = 1'b0;
  logic         fld_ovf = 1'b0;

  char_word_t     pending_chars[$];
  number_result_t expected_numbers[$];
  logic [7:0]     field_text[$];

  int unsigned chars_queued = 0;
  int unsigned chars_taken = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  logic        no_idle = 1'b0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  decimal_number_string_parser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .magnitude_o   (magnitude_o),
    .negative_o    (negative_o),
    .overflow_o    (overflow_o),
    .scale_shift_o (scale_shift_o),
    .precision_o   (precision_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic digit_fits(input logic [3:0] d);
    return (fld_value < lim_div10) || (fld_value == lim_div10 && d <= lim_last);
  endfunction

  // Advance the field model by one character; a field end yields one result.
  task automatic parse_char(input logic [7:0] code, input logic last);
    logic           blank;
    logic [3:0]     d;
    number_result_t res;
    blank = (code == " ") || (code == "\t");
    // ASCII digits sit at 0x30..0x39, so the low nibble is the value
    d = code[3:0];
    if (ps == PS_BAD) begin
    end else if (trail) begin
      if (!blank) ps = PS_BAD;
    end else if (code >= "0" && code <= "9") begin
      case (ps)
        PS_EMPTY, PS_SIGN:       ps = PS_INT;
        PS_FLOAT:                ps = PS_FRACT;
        PS_EXP, PS_EXP_SIGN:     ps = PS_EXP_DIGITS;
        default: ;
      endcase
      case (ps)
        PS_INT: begin
          if (fld_digits != 8'd255) fld_digits++;
          if (digit_fits(d)) fld_value = fld_value * 64'd10 + 64'(d);
          else fld_ovf = 1'b1;
        end
        PS_FRACT: begin
          if (keep_frac && digit_fits(d) && fld_frac < FRAC_MAX) begin
            if (fld_digits != 8'd255) fld_digits++;
            fld_frac++;
            fld_value = fld_value * 64'd10 + 64'(d);
          end
        end
        PS_EXP_DIGITS: begin
          // drop exponent digits once past the limit, flagging overflow
          if (fld_exp > 32'(EXP_LIMIT)) fld_ovf = 1'b1;
          else fld_exp = fld_exp * 32'd10 + 32'(d);
        end
        default: ;
      endcase
    end else if (code == ".") begin
      ps = (ps == PS_INT) ? PS_FLOAT : PS_BAD;
    end else if (code == "e" || code == "E") begin
      ps = (ps == PS_INT || ps == PS_FLOAT || ps == PS_FRACT) ? PS_EXP : PS_BAD;
    end else if (code == "+" || code == "-") begin
      if (ps == PS_EMPTY) begin
        if (code == "-") fld_neg = 1'b1;
        ps = PS_SIGN;
      end else if (ps == PS_EXP) begin
        ps = PS_EXP_SIGN;
      end else begin
        ps = PS_BAD;
      end
    end else if (blank) begin
      if (ps != PS_EMPTY) trail = 1'b1;
    end else begin
      ps = PS_BAD;
    end

    if (last) begin
      res = '0;
      if (ps == PS_FLOAT || ps == PS_FRACT || ps == PS_EXP_DIGITS) res.kind = KIND_FLOAT;
      else if (ps == PS_INT) res.kind = KIND_INT;
      else res.kind = KIND_BAD;
      if (res.kind != KIND_BAD) begin
        res.overflow    = fld_ovf || (!allow_negative && fld_neg && fld_value != 64'd0);
        res.magnitude   = fld_value;
        res.negative    = fld_neg && !res.overflow;
        res.scale_shift = keep_frac ? 25'(32'(fld_frac) - fld_exp) : 25'sd0;
        res.precision   = fld_digits;
      end
      expected_numbers.push_back(res);
      ps = PS_EMPTY;
      trail = 1'b0;
      fld_value = 64'd0;
      fld_exp = 32'd0;
      fld_frac = 5'd0;
      fld_digits = 8'd0;
      fld_neg = 1'b0;
      fld_ovf = 1'b0;
    end
  endtask

  // Driver: take the word on the bus, then present the next one after its gap
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        parse_char(char_code_i, is_last_i);
        chars_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          char_code_i <= pending_chars[0].code;
          is_last_i   <= pending_chars[0].last;
          in_valid_i  <= 1'b1;
          void'(pending_chars.pop_front());
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        if (expected_numbers.size() == 0) begin
          $error("result with no field pending: kind %0d magnitude %0d", kind_o, magnitude_o);
          mismatches++;
        end else begin
          if (kind_o !== expected_numbers[0].kind) begin
            $error("kind: expected %0d, got %0d", expected_numbers[0].kind, kind_o);
            mismatches++;
          end
          if (magnitude_o !== expected_numbers[0].magnitude) begin
            $error("magnitude: expected %0d, got %0d", expected_numbers[0].magnitude,
                   magnitude_o);
            mismatches++;
          end
          if (negative_o !== expected_numbers[0].negative) begin
            $error("negative: expected %0d, got %0d", expected_numbers[0].negative, negative_o);
            mismatches++;
          end
          if (overflow_o !== expected_numbers[0].overflow) begin
            $error("overflow: expected %0d, got %0d", expected_numbers[0].overflow, overflow_o);
            mismatches++;
          end
          if (scale_shift_o !== expected_numbers[0].scale_shift) begin
            $error("scale_shift: expected %0d, got %0d", expected_numbers[0].scale_shift,
                   scale_shift_o);
            mismatches++;
          end
          if (precision_o !== expected_numbers[0].precision) begin
            $error("precision: expected %0d, got %0d", expected_numbers[0].precision,
                   precision_o);
            mismatches++;
          end
          void'(expected_numbers.pop_front());
        end
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
      else stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire || cfg_fire) begin
        idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  task automatic push_word(input logic [7:0] code, input logic last);
    char_word_t w;
    w.code = code;
    w.last = last;
    pending_chars.push_back(w);
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1);
  endtask

  task automatic append_digits(input int unsigned n);
    repeat (n) field_text.push_back(8'("0" + $urandom_range(0, 9)));
  endtask

  // Mostly well-formed numbers with random content, some noise and corrupted text.
  task automatic queue_random_field();
    int unsigned pick;
    int unsigned pos;
    string       edge_text;
    field_text.delete();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 6)) field_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) field_text.push_back($urandom_range(0, 1) ? " " : "\t");
      case ($urandom_range(0, 2))
        1: field_text.push_back("+");
        2: field_text.push_back("-");
        default: ;
      endcase
      if ($urandom_range(0, 19) == 0) begin
        // right at the configured limit, last digit on either side of it
        edge_text = $sformatf("%0d%0d", lim_div10, $urandom_range(0, 9));
        for (int i = 0; i < edge_text.len(); i++) field_text.push_back(edge_text[i]);
      end else if ($urandom_range(0, 9) == 0) begin
        append_digits($urandom_range(15, 22));
      end else begin
        append_digits($urandom_range(1, 6));
      end
      if ($urandom_range(0, 2) != 0) begin
        field_text.push_back(".");
        append_digits(($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                                  : $urandom_range(0, 4));
      end
      if ($urandom_range(0, 3) == 0) begin
        field_text.push_back($urandom_range(0, 1) ? "e" : "E");
        case ($urandom_range(0, 2))
          1: field_text.push_back("+");
          2: field_text.push_back("-");
          default: ;
        endcase
        append_digits(($urandom_range(0, 4) == 0) ? $urandom_range(6, 9)
                                                  : $urandom_range(1, 3));
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) field_text.push_back($urandom_range(0, 1) ? " " : "\t");
      if (pick < 25) begin
        pos = $urandom_range(0, field_text.size() - 1);
        field_text[pos] = 8'($urandom_range(0, 255));
      end
    end
    for (int i = 0; i < field_text.size(); i++)
      push_word(field_text[i], i == field_text.size() - 1);
  endtask

  // Hold the sender until every word is taken and every result is back.
  task automatic drain();
    while (chars_taken != chars_queued || expected_numbers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [63:0] div10, input logic [3:0] last_d,
                            input logic sgn, input logic keep);
    logic [7:0]  idx [4];
    logic [63:0] vals [4];
    idx[0] = CFG_MAX_DIV10;      vals[0] = div10;
    idx[1] = CFG_LAST_DIGIT;     vals[1] = 64'(last_d);
    idx[2] = CFG_SIGNED_TARGET;  vals[2] = 64'(sgn);
    idx[3] = CFG_KEEP_FRACTION;  vals[3] = 64'(keep);
    for (int i = 0; i < 4; i++) begin
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        CFG_MAX_DIV10:     lim_div10 = vals[i];
        CFG_LAST_DIGIT:    lim_last = vals[i][3:0];
        CFG_SIGNED_TARGET: allow_negative = vals[i][0];
        CFG_KEEP_FRACTION: keep_frac = vals[i][0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned stop_at;
    stop_at = chars_queued + n;
    while (chars_queued < stop_at) queue_random_field();
    drain();
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);

    // Reset configuration: one of each character class and the odd endings
    push_text("7");
    push_text("-");
    push_text("\t");
    push_word(8'h00, 1'b1);
    push_word(8'hFF, 1'b1);
    push_text("1.");
    push_text("+2.5");
    push_text("3e");
    push_text("4E-9");
    push_text("1 2");
    push_text("-0 ");
    push_text("-5");
    push_text("1e9999999");
    drain();

    set_config(64'd922337203685477580, 4'd7, 1'b1, 1'b1);
    random_phase(150);
    set_config(64'd0, 4'd0, 1'b0, 1'b0);
    random_phase(140);
    set_config('1, 4'd15, 1'b1, 1'b1);
    random_phase(140);
    no_idle = 1'b1;
    set_config(64'd25, 4'd5, 1'b1, 1'b0);
    random_phase(120);
    no_idle = 1'b0;
    set_config(MAX_DIV10_RST, LAST_DIGIT_RST, 1'b0, 1'b1);
    random_phase(150);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
